/* rtl/core/assert_macros.svh */
// Assertion macros shared by the box filter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define BF3_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define BF3_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/bf3_pkg.sv */
// Types and constants for the 3x3 box filter.
package bf3_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int MAX_COLS    = 1024;
  localparam int COL_W       = $clog2(MAX_COLS);
  localparam int ROW_W       = 12;
  localparam int ROWCNT_W    = 13;
  localparam int COLCNT_W    = 11;
  localparam int ROW_LIMIT   = 4096;
  localparam int CFG_IDX_W   = 8;
  localparam int CFG_DATA_W  = 13;

  localparam int CSUM_W  = SAMPLE_BITS + 2;
  localparam int SUM_W   = SAMPLE_BITS + 4;
  localparam int MAG_W   = SAMPLE_BITS + 3;
  localparam int DIV_SH  = MAG_W + 4;
  localparam int DIV_M_W = DIV_SH - 3;
  localparam int PROD_W  = MAG_W + DIV_M_W;

  // ceil(2^DIV_SH / 9): exact floor division for magnitudes below 2^MAG_W
  localparam logic [DIV_M_W-1:0] DIV_M = DIV_M_W'(((64'd1 << DIV_SH) + 64'd8) / 64'd9);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW_COUNT = 8'd0,
    REG_COL_COUNT = 8'd1
  } cfg_reg_t;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  typedef struct packed {
    sample_t two_up;
    sample_t one_up;
  } line_pair_t;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last;
  } meta_t;

  typedef struct packed {
    logic    emit;
    meta_t   meta;
    sample_t bot;
  } s1_word_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] total;
    meta_t                   meta;
  } s2_word_t;

endpackage

/* rtl/core/bf3_ifs.sv */
// Valid/ready channel interfaces: sample in, result out, register write.
interface bf3_in_if import bf3_pkg::*;;
  logic    valid;
  logic    ready;
  sample_t sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface bf3_out_if import bf3_pkg::*;;
  logic             valid;
  logic             ready;
  logic [ROW_W-1:0] out_row;
  logic [COL_W-1:0] out_col;
  sample_t          smoothed;
  logic             last_of_frame;

  modport source (output valid, output out_row, output out_col, output smoothed,
                  output last_of_frame, input ready);
  modport sink (input valid, input out_row, input out_col, input smoothed,
                input last_of_frame, output ready);
endinterface

interface bf3_cfg_if import bf3_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

/* rtl/core/bf3_linebuf.sv */
// Two-row line buffer: one write and one registered read per cycle.
module bf3_linebuf import bf3_pkg::*; (
  input  logic             clk,
  input  logic [COL_W-1:0] rd_addr,
  output line_pair_t       rd_data,
  input  logic             wr_en,
  input  logic [COL_W-1:0] wr_addr,
  input  line_pair_t       wr_data
);

  line_pair_t mem [MAX_COLS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

/* rtl/core/bf3_window.sv */
// Column sums, two-column window and 3x3 total register.
module bf3_window import bf3_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  s1_word_t s1,
  input  logic     s1_adv,
  input  sample_t  top,
  input  sample_t  mid,
  output logic     win_ready,
  output logic     dn_valid,
  output s2_word_t dn_word,
  input  logic     dn_ready
);

  logic signed [CSUM_W-1:0] colsum;
  logic signed [CSUM_W-1:0] w_a_r;
  logic signed [CSUM_W-1:0] w_b_r;
  logic signed [SUM_W-1:0]  total;
  logic                     s2_valid_r;
  s2_word_t                 s2_word_r;

  always_comb begin
    colsum    = CSUM_W'(top) + CSUM_W'(mid) + CSUM_W'(s1.bot);
    total     = SUM_W'(colsum) + SUM_W'(w_a_r) + SUM_W'(w_b_r);
    win_ready = !s2_valid_r || dn_ready;
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      w_a_r <= colsum;
      w_b_r <= w_a_r;
    end
    if (s1_adv && s1.emit) begin
      s2_word_r.total <= total;
      s2_word_r.meta  <= s1.meta;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s1_adv && s1.emit) begin
      s2_valid_r <= 1'b1;
    end else if (dn_ready) begin
      s2_valid_r <= 1'b0;
    end
  end

  assign dn_valid = s2_valid_r;
  assign dn_word  = s2_word_r;

endmodule

/* rtl/core/bf3_div9.sv */
// Signed divide by nine, truncating toward zero, and the result register.
module bf3_div9 import bf3_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     up_valid,
  input  s2_word_t up_word,
  output logic     up_ready,
  bf3_out_if.source out_ch
);

  logic                    s3_valid_r;
  logic [MAG_W-1:0]        s3_mag_r;
  logic                    s3_neg_r;
  meta_t                   s3_meta_r;
  logic                    s4_valid_r;
  logic [SAMPLE_BITS-1:0]  s4_q_r;
  logic                    s4_neg_r;
  meta_t                   s4_meta_r;
  logic                    out_valid_r;
  sample_t                 out_smoothed_r;
  meta_t                   out_meta_r;

  logic                    out_free;
  logic                    s4_free;
  logic                    s3_free;
  logic                    up_fire;
  logic                    s3_adv;
  logic                    s4_adv;
  logic signed [SUM_W-1:0] neg_total;
  logic [MAG_W-1:0]        mag;
  logic [PROD_W-1:0]       prod;
  logic [SAMPLE_BITS-1:0]  q_signed;

  always_comb begin
    out_free  = !out_valid_r || out_ch.ready;
    s4_free   = !s4_valid_r || out_free;
    s3_free   = !s3_valid_r || s4_free;
    up_ready  = s3_free;
    up_fire   = up_valid && s3_free;
    s3_adv    = s3_valid_r && s4_free;
    s4_adv    = s4_valid_r && out_free;
    neg_total = -up_word.total;
    mag       = up_word.total[SUM_W-1] ? neg_total[MAG_W-1:0] : up_word.total[MAG_W-1:0];
    prod      = PROD_W'(s3_mag_r) * PROD_W'(DIV_M);
    q_signed  = s4_neg_r ? -s4_q_r : s4_q_r;
  end

  always_ff @(posedge clk) begin
    if (up_fire) begin
      s3_mag_r  <= mag;
      s3_neg_r  <= up_word.total[SUM_W-1];
      s3_meta_r <= up_word.meta;
    end
    if (s3_adv) begin
      s4_q_r    <= prod[DIV_SH +: SAMPLE_BITS];
      s4_neg_r  <= s3_neg_r;
      s4_meta_r <= s3_meta_r;
    end
    if (s4_adv) begin
      out_smoothed_r <= q_signed;
      out_meta_r     <= s4_meta_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r  <= 1'b0;
      s4_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (up_fire) begin
        s3_valid_r <= 1'b1;
      end else if (s3_adv) begin
        s3_valid_r <= 1'b0;
      end
      if (s3_adv) begin
        s4_valid_r <= 1'b1;
      end else if (s4_adv) begin
        s4_valid_r <= 1'b0;
      end
      if (s4_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.out_row       = out_meta_r.row;
  assign out_ch.out_col       = out_meta_r.col;
  assign out_ch.smoothed      = out_smoothed_r;
  assign out_ch.last_of_frame = out_meta_r.last;

endmodule

/* rtl/core/box_filter_3x3_interior.sv */
// Top level of the streaming 3x3 box filter (interior elements only).
// Throughput: one sample per cycle while the output channel is not stalled; each accepted
// sample passes through the line buffer read, window sum, magnitude, multiply
// and result register stages. Border samples make no result.
// Reset: 3x3 frame, position (0,0), pipeline empty; line buffers are not cleared.
`include "assert_macros.svh"

module box_filter_3x3_interior import bf3_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  bf3_in_if.sink     in_ch,
  bf3_out_if.source  out_ch,
  bf3_cfg_if.sink    cfg_ch
);

  logic [ROWCNT_W-1:0] rows_eff_r;
  logic [ROWCNT_W-1:0] rows_eff_nxt;
  logic [COL_W:0]      cols_eff_r;
  logic [COL_W:0]      cols_eff_nxt;
  logic [ROW_W-1:0]    row_pos_r;
  logic [COL_W-1:0]    col_pos_r;

  logic                s1_valid_r;
  s1_word_t            s1_word_r;
  logic [COL_W-1:0]    s1_col_r;

  logic                cfg_fire;
  logic                cfg_restart;
  logic                in_fire;
  logic                in_ready;
  logic                s1_adv;
  logic                win_ready;
  logic                row_last;
  logic                col_last;
  logic                frame_end;
  logic [COL_W-1:0]    rd_addr;
  line_pair_t          rd_data;
  line_pair_t          wr_data;
  s1_word_t            s1_nxt;
  logic                s2_valid;
  s2_word_t            s2_word;
  logic                s2_ready;
  logic [ROWCNT_W-1:0] cfg_rows;
  logic [COLCNT_W-1:0] cfg_cols;

  assign cfg_ch.ready = 1'b1;
  assign cfg_fire     = cfg_ch.valid;
  assign cfg_restart  = cfg_fire &&
                        (cfg_ch.index == REG_ROW_COUNT || cfg_ch.index == REG_COL_COUNT);
  assign cfg_rows     = cfg_ch.data[ROWCNT_W-1:0];
  assign cfg_cols     = cfg_ch.data[COLCNT_W-1:0];

  always_comb begin
    rows_eff_nxt = rows_eff_r;
    cols_eff_nxt = cols_eff_r;
    unique case (cfg_ch.index)
      REG_ROW_COUNT: begin
        if (cfg_rows == '0) begin
          rows_eff_nxt = ROWCNT_W'(1);
        end else if (cfg_rows > ROWCNT_W'(ROW_LIMIT)) begin
          rows_eff_nxt = ROWCNT_W'(ROW_LIMIT);
        end else begin
          rows_eff_nxt = cfg_rows;
        end
      end
      REG_COL_COUNT: begin
        if (cfg_cols == '0) begin
          cols_eff_nxt = (COL_W+1)'(1);
        end else if ((COL_W+1)'(cfg_cols) > (COL_W+1)'(MAX_COLS)) begin
          cols_eff_nxt = (COL_W+1)'(MAX_COLS);
        end else begin
          cols_eff_nxt = (COL_W+1)'(cfg_cols);
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    s1_adv      = s1_valid_r && (!s1_word_r.emit || win_ready);
    in_ready    = !s1_valid_r || s1_adv;
    in_fire     = in_ch.valid && in_ready;
    rd_addr     = (s1_valid_r && !s1_adv) ? s1_col_r : col_pos_r;
    col_last    = ({1'b0, col_pos_r} + 1'b1) == cols_eff_r;
    row_last    = ({1'b0, row_pos_r} + 1'b1) == rows_eff_r;
    frame_end   = in_fire && row_last && col_last;
    s1_nxt.emit      = (row_pos_r >= ROW_W'(2)) && (col_pos_r >= COL_W'(2));
    s1_nxt.meta.row  = row_pos_r - 1'b1;
    s1_nxt.meta.col  = col_pos_r - 1'b1;
    s1_nxt.meta.last = row_last && col_last;
    s1_nxt.bot       = in_ch.sample;
    wr_data.two_up   = rd_data.one_up;
    wr_data.one_up   = s1_word_r.bot;
  end

  assign in_ch.ready = in_ready;

  // configuration and frame position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_eff_r <= ROWCNT_W'(3);
      cols_eff_r <= (COL_W+1)'(3);
      row_pos_r  <= '0;
      col_pos_r  <= '0;
    end else begin
      if (cfg_fire) begin
        rows_eff_r <= rows_eff_nxt;
        cols_eff_r <= cols_eff_nxt;
      end
      if (cfg_restart) begin
        row_pos_r <= '0;
        col_pos_r <= '0;
      end else if (in_fire) begin
        if (col_last) begin
          col_pos_r <= '0;
          row_pos_r <= row_last ? '0 : row_pos_r + 1'b1;
        end else begin
          col_pos_r <= col_pos_r + 1'b1;
        end
      end
    end
  end

  // line buffer read stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_word_r <= s1_nxt;
      s1_col_r  <= col_pos_r;
    end
  end

  bf3_linebuf u_linebuf (
    .clk     (clk),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (s1_adv),
    .wr_addr (s1_col_r),
    .wr_data (wr_data)
  );

  bf3_window u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .s1        (s1_word_r),
    .s1_adv    (s1_adv),
    .top       (rd_data.two_up),
    .mid       (rd_data.one_up),
    .win_ready (win_ready),
    .dn_valid  (s2_valid),
    .dn_word   (s2_word),
    .dn_ready  (s2_ready)
  );

  bf3_div9 u_div9 (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s2_valid),
    .up_word  (s2_word),
    .up_ready (s2_ready),
    .out_ch   (out_ch)
  );

  `BF3_ASSERT_NOW(a_col_in_frame, 1'b1, {1'b0, col_pos_r} < cols_eff_r, "column past frame")
  `BF3_ASSERT_NOW(a_row_in_frame, 1'b1, {1'b0, row_pos_r} < rows_eff_r, "row past frame")
  `BF3_ASSERT_NEXT(a_frame_wrap, frame_end, row_pos_r == '0 && col_pos_r == '0, "no frame wrap")

endmodule
